FILE: src/tlpt_pkg.sv
// Shared constants, codes and control/status bundles of the page table engine.
// No dependencies; every other file but tlpt_ram imports this package.
package tlpt_pkg;

    // Table geometry
    localparam int TABLE_SLOTS  = 16;
    localparam int IDX_W        = 10;
    localparam int DIR_ENTRIES  = 1 << IDX_W;
    localparam int PAGE_ENTRIES = 1 << IDX_W;
    localparam int OFS_W        = 12;
    localparam int ADDR_W       = 32;
    localparam int FRAME_W      = 20;
    localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W        = $clog2(TABLE_SLOTS + 1);
    localparam int PAGE_DEPTH   = TABLE_SLOTS * PAGE_ENTRIES;
    localparam int PAGE_AW      = $clog2(PAGE_DEPTH);
    localparam int DIR_W        = SLOT_W + 1;
    localparam int PAGE_W       = FRAME_W + 1;

    localparam logic [ADDR_W-1:0] KERNEL_BASE = 32'hC000_0000;

    // Operation codes
    localparam logic [1:0] FN_TRANS = 2'd0;
    localparam logic [1:0] FN_MAP   = 2'd1;
    localparam logic [1:0] FN_UNMAP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_POOL_FULL  = 2'd2;
    localparam logic [1:0] ST_ALREADY    = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic       clr_wr;      // clearing pass writes zero entries
        logic       accept;      // latch a new item
        logic       dir_chk;     // directory read data is valid this cycle
        logic       dir_wr;      // install a new table in the directory
        logic       pg_wr;       // write a page entry
        logic       pg_new;      // page write goes to the freshly allocated table
        logic       pg_zero;     // page write clears present and frame
        logic       res_valid;   // load the result register
        logic       res_bypass;  // result is address minus kernel base
        logic       res_trans;   // result is the translated address
        logic [1:0] res_status;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic paging;
        logic dir_hit;
        logic pool_full;
        logic pg_present;
    } t_sts;

endpackage

FILE: src/tlpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tlpt_ctrl.sv
// Controller of the page table engine: clearing pass, walk sequencing, results.
// Depends on tlpt_pkg for codes and the command/status bundles.
module tlpt_ctrl
    import tlpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_sts       i_sts,
    output t_ctl       o_ctl,
    output logic       o_busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_DIR   = 2'd2;
    localparam logic [1:0] S_PAGE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [1:0] r_func, n_func;
    t_ctl       ctl;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        ctl     = '0;
        unique case (r_state)
            S_CLEAR: begin
                ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    ctl.accept = 1'b1;
                    n_func     = i_func;
                    unique case (i_func)
                        FN_TRANS: begin
                            if (i_sts.paging) begin
                                n_state = S_DIR;
                            end else begin
                                ctl.res_valid  = 1'b1;
                                ctl.res_bypass = 1'b1;
                                ctl.res_status = ST_OK;
                            end
                        end
                        FN_MAP, FN_UNMAP: begin
                            n_state = S_DIR;
                        end
                        default: begin
                            // unused code: no operation
                            ctl.res_valid  = 1'b1;
                            ctl.res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_DIR: begin
                ctl.dir_chk = 1'b1;
                n_state     = S_IDLE;
                if (i_sts.dir_hit) begin
                    n_state = S_PAGE;
                end else if (r_func == FN_MAP) begin
                    ctl.res_valid = 1'b1;
                    if (i_sts.pool_full) begin
                        ctl.res_status = ST_POOL_FULL;
                    end else begin
                        // new table is known clear: write the page at once
                        ctl.dir_wr     = 1'b1;
                        ctl.pg_wr      = 1'b1;
                        ctl.pg_new     = 1'b1;
                        ctl.res_status = ST_OK;
                    end
                end else begin
                    ctl.res_valid  = 1'b1;
                    ctl.res_status = ST_NOT_MAPPED;
                end
            end
            S_PAGE: begin
                n_state       = S_IDLE;
                ctl.res_valid = 1'b1;
                unique case (r_func)
                    FN_TRANS: begin
                        ctl.res_trans  = i_sts.pg_present;
                        ctl.res_status = i_sts.pg_present ? ST_OK : ST_NOT_MAPPED;
                    end
                    FN_MAP: begin
                        ctl.pg_wr      = !i_sts.pg_present;
                        ctl.res_status = i_sts.pg_present ? ST_ALREADY : ST_OK;
                    end
                    default: begin
                        ctl.pg_wr      = i_sts.pg_present;
                        ctl.pg_zero    = 1'b1;
                        ctl.res_status = i_sts.pg_present ? ST_OK : ST_NOT_MAPPED;
                    end
                endcase
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_func  <= FN_TRANS;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
        end
    end

    assign o_ctl  = ctl;
    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // clearing pass never overlaps a table update
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clr_wr |-> !(ctl.dir_wr || ctl.pg_wr || ctl.accept))
        else $error("clear overlaps table update");

    // a table is only installed by a map with room left in the pool
    a_dir_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.dir_wr |-> (r_func == FN_MAP && !i_sts.pool_full && !i_sts.dir_hit))
        else $error("directory write outside map");

    // an accepted map always goes to the directory lookup
    a_map_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.accept && i_func == FN_MAP) |=> (r_state == S_DIR))
        else $error("map did not walk");
`endif

endmodule

FILE: src/tlpt_dpath.sv
// Datapath of the page table engine: directory and page RAMs, pool counter,
// clearing counter, item and result registers. Depends on tlpt_pkg, tlpt_ram.
module tlpt_dpath
    import tlpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    output t_sts               o_sts,
    input  logic [ADDR_W-1:0]  i_virt_addr,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_strobe,
    output logic [ADDR_W-1:0]  o_phys_addr,
    output logic [1:0]         o_status
);

    logic [ADDR_W-1:0]  r_addr;
    logic [FRAME_W-1:0] r_frame;
    logic [SLOT_W-1:0]  r_slot;
    logic [CNT_W-1:0]   r_used;
    logic [PAGE_AW-1:0] r_clr;
    logic               r_paging;
    logic               r_strobe;
    logic [ADDR_W-1:0]  r_phys;
    logic [1:0]         r_status;
    logic [ADDR_W-1:0]  n_phys;

    logic [IDX_W-1:0]   dir_idx, pg_idx;
    logic [SLOT_W-1:0]  new_slot, rd_slot;
    logic               dir_we, pg_we;
    logic [IDX_W-1:0]   dir_waddr;
    logic [DIR_W-1:0]   dir_wdata, dir_rdata;
    logic [PAGE_AW-1:0] pg_waddr, pg_raddr;
    logic [PAGE_W-1:0]  pg_wdata, pg_rdata;

    assign dir_idx  = r_addr[ADDR_W-1 -: IDX_W];
    assign pg_idx   = r_addr[OFS_W +: IDX_W];
    assign new_slot = SLOT_W'(r_used);
    assign rd_slot  = dir_rdata[SLOT_W-1:0];

    // Directory: valid bit over slot number
    assign dir_we    = i_ctl.clr_wr | i_ctl.dir_wr;
    assign dir_waddr = i_ctl.clr_wr ? r_clr[IDX_W-1:0] : dir_idx;
    assign dir_wdata = i_ctl.clr_wr ? '0 : {1'b1, new_slot};

    tlpt_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (i_virt_addr[ADDR_W-1 -: IDX_W]),
        .o_rdata (dir_rdata)
    );

    // Page entries: present bit over frame number
    assign pg_we    = i_ctl.clr_wr | i_ctl.pg_wr;
    assign pg_raddr = PAGE_AW'({rd_slot, pg_idx});
    always_comb begin
        priority if (i_ctl.clr_wr) begin
            pg_waddr = r_clr;
        end else if (i_ctl.pg_new) begin
            pg_waddr = PAGE_AW'({new_slot, pg_idx});
        end else begin
            pg_waddr = PAGE_AW'({r_slot, pg_idx});
        end
    end
    assign pg_wdata = (i_ctl.clr_wr || i_ctl.pg_zero) ? '0 : {1'b1, r_frame};

    tlpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (PAGE_DEPTH)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    // Latch the item and the slot found in the directory
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_addr  <= i_virt_addr;
            r_frame <= i_frame;
        end
        if (i_ctl.dir_chk) begin
            r_slot <= rd_slot;
        end
    end

    // Control state: clearing counter, pool fill, paging register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_used   <= '0;
            r_paging <= 1'b0;
        end else begin
            if (i_ctl.clr_wr) begin
                r_clr <= r_clr + PAGE_AW'(1);
            end
            if (i_ctl.dir_wr) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_paging <= i_cfg_wdata;
            end
        end
    end

    // Result selection
    always_comb begin
        priority if (i_ctl.res_bypass) begin
            n_phys = i_virt_addr - KERNEL_BASE;
        end else if (i_ctl.res_trans) begin
            n_phys = {pg_rdata[FRAME_W-1:0], r_addr[OFS_W-1:0]};
        end else begin
            n_phys = '0;
        end
    end

    // Result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_valid) begin
            r_phys   <= n_phys;
            r_status <= i_ctl.res_status;
        end
    end

    assign o_sts.clr_last   = (r_clr == PAGE_AW'(PAGE_DEPTH - 1));
    assign o_sts.paging     = r_paging;
    assign o_sts.dir_hit    = dir_rdata[SLOT_W];
    assign o_sts.pool_full  = (r_used >= CNT_W'(TABLE_SLOTS));
    assign o_sts.pg_present = pg_rdata[FRAME_W];

    assign o_strobe    = r_strobe;
    assign o_phys_addr = r_phys;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    // pool fill never passes the number of tables
    a_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_SLOTS))
        else $error("pool count overflow");

    // a failed operation reports address zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status != ST_OK) |-> (r_phys == '0))
        else $error("nonzero address on failed item");
`endif

endmodule

FILE: src/two_level_page_table_engine.sv
// Top level of the two-level page table engine.
// Depends on tlpt_pkg, tlpt_ctrl, tlpt_dpath (which holds two tlpt_ram).
//
//  channel   handshake             payload
//  item in   start & !busy         i_func, i_virt_addr, i_frame
//  result    o_strobe (one cycle)  o_phys_addr, o_status
//  config    i_cfg_we              i_cfg_wdata (paging enable)
//
// The result is registered from the accept cycle for unpaged translate and
// unused codes, from the directory state for a map installing a new table or
// a failed directory lookup, from the page state when a page entry is read;
// the next item can be taken in the strobe cycle. Two dependent RAM reads set
// this order. After reset a clearing pass of TABLE_SLOTS*1024 (16384)
// entries zeroes both RAMs with busy high; config writes are taken meanwhile.
// The receiver cannot stall: each result is valid for its strobe cycle only.
module two_level_page_table_engine
    import tlpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [ADDR_W-1:0]  i_virt_addr,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    output logic               o_strobe,
    output logic [ADDR_W-1:0]  o_phys_addr,
    output logic [1:0]         o_status
);

    t_ctl ctl;
    t_sts sts;

    // Sequencer
    tlpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // Tables and result registers
    tlpt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_virt_addr (i_virt_addr),
        .i_frame     (i_frame),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_phys_addr (o_phys_addr),
        .o_status    (o_status)
    );

endmodule
